[rtl/slfd_pkg.sv]
package slfd_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  localparam logic [16:0] POS_MAX   = 17'h1FFFF;
  localparam logic [17:0] MIN_FRAME = 18'd8;
  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;

  localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] CFG_MAX_LEN     = 2'd2;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_SHORT = 3'd1,
    ST_SYNC  = 3'd2,
    ST_LEN   = 3'd3,
    ST_CRC   = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [15:0] max_len;
  } cfg_t;

  // one classified byte, front to back
  typedef struct packed {
    logic [7:0]  data;
    logic        crc_upd;   // payload byte: feeds the CRC
    logic        emit;      // payload byte goes out
    logic        rcv_upd;   // byte of the trailing CRC
    logic [1:0]  rcv_idx;
    logic        last;
    logic        chk_crc;   // header checks passed, CRC decides
    status_t     pre_status;
    logic [15:0] len;
  } entry_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[rtl/slfd_front.sv]
module slfd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  slfd_pkg::cfg_t  cfg,
  input  logic            accept,
  input  logic [7:0]      data_byte,
  input  logic            end_of_buffer,
  output slfd_pkg::entry_t entry
);
  import slfd_pkg::*;

  logic [16:0] pos_r, pos_nxt;
  logic [15:0] len_r, len_nxt;
  logic        sync_r, sync_nxt;

  logic [17:0] pos18, pay_end, crc_end, blen, need;
  logic [17:0] rcv_off;
  logic        pay, rcv;

  always_comb begin
    pos18    = {1'b0, pos_r};
    pay_end  = {2'b00, len_r} + 18'd4;
    crc_end  = {2'b00, len_r} + 18'd8;
    rcv_off  = pos18 - pay_end;
    sync_nxt = sync_r;
    len_nxt  = len_r;
    pay      = 1'b0;
    rcv      = 1'b0;
    priority if (pos_r == 17'd0) begin
      sync_nxt = (data_byte == cfg.sync_first);
    end else if (pos_r == 17'd1) begin
      sync_nxt = sync_r && (data_byte == cfg.sync_second);
    end else if (pos_r == 17'd2) begin
      len_nxt[7:0] = data_byte;
    end else if (pos_r == 17'd3) begin
      len_nxt[15:8] = data_byte;
    end else if (pos18 < pay_end) begin
      pay = 1'b1;
    end else if (pos18 < crc_end) begin
      rcv = 1'b1;
    end
  end

  always_comb begin
    blen = pos18 + 18'd1;
    need = {2'b00, len_nxt} + 18'd8;
    entry.data    = data_byte;
    entry.crc_upd = pay;
    entry.emit    = pay && sync_r && (len_r <= cfg.max_len);
    entry.rcv_upd = rcv;
    entry.rcv_idx = rcv_off[1:0];
    entry.last    = end_of_buffer;
    entry.len     = len_nxt;
    entry.chk_crc = 1'b0;
    priority if (blen < MIN_FRAME) begin
      entry.pre_status = ST_SHORT;
    end else if (!sync_nxt) begin
      entry.pre_status = ST_SYNC;
    end else if ((len_nxt > cfg.max_len) || (need > blen)) begin
      entry.pre_status = ST_LEN;
    end else begin
      entry.pre_status = ST_OK;
      entry.chk_crc    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      len_r  <= '0;
      sync_r <= 1'b1;
    end else if (accept) begin
      if (end_of_buffer) begin
        pos_r  <= '0;
        len_r  <= '0;
        sync_r <= 1'b1;
      end else begin
        pos_r  <= (pos_r == POS_MAX) ? pos_r : pos_r + 17'd1;
        len_r  <= len_nxt;
        sync_r <= sync_nxt;
      end
    end
  end

endmodule

[rtl/slfd_queue.sv]
module slfd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  slfd_pkg::entry_t wr_entry,
  output logic             full,
  input  logic             pop,
  output logic             rd_valid,
  output slfd_pkg::entry_t rd_entry
);
  import slfd_pkg::*;

  entry_t         mem [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0] cnt_r;

  assign full     = (cnt_r == QCW'(QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_entry = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QAW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QAW'(1);
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + QCW'(1);
        2'b01:   cnt_r <= cnt_r - QCW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

[rtl/slfd_back.sv]
module slfd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  slfd_pkg::entry_t q_entry,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_is_status,
  output logic [7:0]       out_payload_byte,
  output logic [2:0]       out_frame_status,
  output logic [15:0]      out_payload_len
);
  import slfd_pkg::*;

  logic [31:0] crc_r, rcv_r;
  logic [31:0] crc_new, rcv_new;
  logic        out_valid_r, pend_r;
  status_t     pend_status_r, status;
  logic [15:0] pend_len_r;
  logic        out_is_status_r;
  logic [7:0]  out_byte_r;
  status_t     out_status_r;
  logic [15:0] out_len_r;
  logic        out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign pop      = q_valid && out_free && !pend_r;

  always_comb begin
    crc_new = q_entry.crc_upd ? crc_byte(crc_r, q_entry.data) : crc_r;
    rcv_new = rcv_r;
    if (q_entry.rcv_upd) begin
      unique case (q_entry.rcv_idx)
        2'd0: rcv_new[7:0]   = q_entry.data;
        2'd1: rcv_new[15:8]  = q_entry.data;
        2'd2: rcv_new[23:16] = q_entry.data;
        2'd3: rcv_new[31:24] = q_entry.data;
        default: rcv_new = rcv_r;
      endcase
    end
    if (q_entry.chk_crc) begin
      status = ((crc_new ^ CRC_INIT) != rcv_new) ? ST_CRC : ST_OK;
    end else begin
      status = q_entry.pre_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
      rcv_r <= '0;
    end else if (pop) begin
      crc_r <= q_entry.last ? CRC_INIT : crc_new;
      rcv_r <= q_entry.last ? 32'd0 : rcv_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else if (out_free) begin
      if (pend_r) begin
        out_valid_r <= 1'b1;
        pend_r      <= 1'b0;
      end else if (pop && (q_entry.emit || q_entry.last)) begin
        out_valid_r <= 1'b1;
        pend_r      <= q_entry.emit && q_entry.last;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (pend_r) begin
        out_is_status_r <= 1'b1;
        out_byte_r      <= '0;
        out_status_r    <= pend_status_r;
        out_len_r       <= pend_len_r;
      end else if (pop && q_entry.emit) begin
        out_is_status_r <= 1'b0;
        out_byte_r      <= q_entry.data;
        out_status_r    <= ST_OK;
        out_len_r       <= '0;
        pend_status_r   <= status;
        pend_len_r      <= q_entry.len;
      end else if (pop && q_entry.last) begin
        out_is_status_r <= 1'b1;
        out_byte_r      <= '0;
        out_status_r    <= status;
        out_len_r       <= q_entry.len;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_is_status    = out_is_status_r;
  assign out_payload_byte = out_byte_r;
  assign out_frame_status = out_status_r;
  assign out_payload_len  = out_len_r;

endmodule

[rtl/sync_length_crc_deframer.sv]
// Sync / length / payload / CRC-32 deframer, one byte item per cycle while the queue has room.
// A byte's result is registered in the queue and then in the output stage.
// Throughput: one byte per cycle while the queue has room; a last byte that also carries
// payload yields two results and holds the back end until the second one is out.
// Reset (rst_n, synchronous, active low) clears frame state, queue and
// output, and sets sync bytes to 0 and maximum length to 65535.
module sync_length_crc_deframer (
  input  logic        clk,
  input  logic        rst_n,
  // byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_buffer,
  // results
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_is_status,
  output logic [7:0]  out_payload_byte,
  output logic [2:0]  out_frame_status,
  output logic [15:0] out_payload_len,
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import slfd_pkg::*;

  cfg_t   cfg_r;
  entry_t f_entry, q_entry;
  logic   in_accept, q_full, q_valid, q_pop;

  // Configuration registers; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first  <= 8'd0;
      cfg_r.sync_second <= 8'd0;
      cfg_r.max_len     <= 16'hFFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SYNC_FIRST:  cfg_r.sync_first  <= cfg_wdata[7:0];
        CFG_SYNC_SECOND: cfg_r.sync_second <= cfg_wdata[7:0];
        CFG_MAX_LEN:     cfg_r.max_len     <= cfg_wdata;
        default:         cfg_r             <= cfg_r;
      endcase
    end
  end

  // Front end: the queue being full is the only thing that stalls input.
  assign in_stall  = q_full;
  assign in_accept = in_valid && !q_full;

  // Front: byte position, header length and sync check; each item is
  // tagged as payload, CRC byte or ignored, with the header-side status.
  slfd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .accept        (in_accept),
    .data_byte     (in_data_byte),
    .end_of_buffer (in_end_of_buffer),
    .entry         (f_entry)
  );

  // Short queue so front and back stall independently.
  slfd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_accept),
    .wr_entry (f_entry),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_entry (q_entry)
  );

  // Back: bytewise CRC, received CRC capture, final status and the
  // registered output stage.
  slfd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_entry          (q_entry),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_is_status    (out_is_status),
    .out_payload_byte (out_payload_byte),
    .out_frame_status (out_frame_status),
    .out_payload_len  (out_payload_len)
  );

endmodule

[bench/sync_length_crc_deframer_test.sv]
module sync_length_crc_deframer_test;
  import slfd_pkg::*;

  // reflected IEEE CRC-32 polynomial, kept local to the bench predictor
  localparam logic [31:0] REFL_POLY   = 32'hEDB88320;
  localparam int          MIN_BYTES   = 8;
  localparam int          WATCHDOG    = 2000;    // cycles without any handshake
  localparam int          LONG_HOLD   = 80;      // receiver hold-off, fills the block
  localparam int          PHASE_ITEMS = 180;     // frame bytes per random phase
  localparam int          N_PHASES    = 8;

  // one result item as the block should produce it
  typedef struct {
    logic        is_status;
    logic [7:0]  payload_byte;
    logic [2:0]  frame_status;
    logic [15:0] payload_len;
  } deframed_t;

  // directed stimulus: the status is typed in only on last-byte rows
  typedef struct packed {
    logic [7:0]  data;
    logic        eob;
    logic        typed;
    status_t     status;
    logic [15:0] len;
  } bench_row_t;

  typedef struct packed {
    logic [7:0]  sync_a;
    logic [7:0]  sync_b;
    logic [15:0] lim;
    logic [6:0]  tx_pct;
    logic [6:0]  rx_pct;
    logic        hold;
  } phase_plan_t;

  logic        clk              = 1'b0;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte     = 8'd0;
  logic        in_end_of_buffer = 1'b0;
  logic        out_valid;
  logic        out_stall        = 1'b0;
  logic        out_is_status;
  logic [7:0]  out_payload_byte;
  logic [2:0]  out_frame_status;
  logic [15:0] out_payload_len;
  logic        cfg_we           = 1'b0;
  logic [1:0]  cfg_index        = CFG_SYNC_FIRST;
  logic [15:0] cfg_wdata        = 16'd0;

  sync_length_crc_deframer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_end_of_buffer (in_end_of_buffer),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_is_status    (out_is_status),
    .out_payload_byte (out_payload_byte),
    .out_frame_status (out_frame_status),
    .out_payload_len  (out_payload_len),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: registers as the block should hold them, and the frame
  // being parsed. Updated only from handshakes seen at the clock edge.
  // ---------------------------------------------------------------------------
  logic [7:0]  want_sync_a;
  logic [7:0]  want_sync_b;
  logic [15:0] len_limit;
  logic [16:0] rx_pos;
  logic [15:0] rx_len;
  logic [31:0] crc_acc;
  logic [31:0] rx_crc;
  logic        sync_ok;

  deframed_t pending_results[$];   // predicted items, oldest first
  deframed_t typed_status_q[$];    // hand-written statuses of the directed rows

  int mismatches      = 0;
  int results_checked = 0;
  int status_seen [0:4] = '{0, 0, 0, 0, 0};

  // stimulus-side copies of the current register plan and flow control
  logic [7:0]  gen_sa;
  logic [7:0]  gen_sb;
  logic [15:0] gen_lim;
  int          tx_gap_pct   = 0;
  int          rx_stall_pct = 0;
  int          hold_req     = 0;

  function automatic logic [31:0] crc32_update(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) c = c ^ REFL_POLY;
    end
    return c;
  endfunction

  function automatic void restart_frame();
    rx_pos  = 17'd0;
    rx_len  = 16'd0;
    crc_acc = 32'hFFFF_FFFF;
    rx_crc  = 32'd0;
    sync_ok = 1'b1;
  endfunction

  // One accepted byte: walk the frame layout, queue any payload item and,
  // on the buffer's last byte, the status item.
  function automatic void deframe_byte(logic [7:0] b, logic eob);
    int      pos;
    int      len;
    int      blen;
    status_t st;
    pos = int'(rx_pos);
    len = int'(rx_len);
    if (pos == 0) sync_ok = (b == want_sync_a);
    else if (pos == 1) sync_ok = sync_ok && (b == want_sync_b);
    else if (pos == 2) rx_len[7:0] = b;
    else if (pos == 3) rx_len[15:8] = b;
    else if (pos < 4 + len) begin
      crc_acc = crc32_update(crc_acc, b);
      if (sync_ok && len <= int'(len_limit))
        pending_results.push_back('{1'b0, b, 3'd0, 16'd0});
    end else if (pos < 8 + len)
      rx_crc[(pos - 4 - len) * 8 +: 8] = b;   // trailer is little-endian
    // position saturates; bytes that far out are past any frame anyway
    if (rx_pos != '1) rx_pos = rx_pos + 17'd1;
    if (eob) begin
      blen = pos + 1;
      len  = int'(rx_len);
      // priority: short, sync, length, CRC
      if (blen < MIN_BYTES) st = ST_SHORT;
      else if (!sync_ok) st = ST_SYNC;
      else if (len > int'(len_limit) || len + MIN_BYTES > blen) st = ST_LEN;
      else if (~crc_acc != rx_crc) st = ST_CRC;
      else st = ST_OK;
      pending_results.push_back('{1'b1, 8'd0, st, rx_len});
      restart_frame();
    end
  endfunction

  function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: register writes, accepted bytes and accepted results, all
  // sampled at the rising edge from values settled before it.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    deframed_t want;
    if (!rst_n) begin
      want_sync_a = 8'd0;
      want_sync_b = 8'd0;
      len_limit   = 16'hFFFF;
      restart_frame();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SYNC_FIRST:  want_sync_a = cfg_wdata[7:0];
          CFG_SYNC_SECOND: want_sync_b = cfg_wdata[7:0];
          CFG_MAX_LEN:     len_limit   = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) deframe_byte(in_data_byte, in_end_of_buffer);
      if (out_valid && !out_stall) begin
        results_checked++;
        if (pending_results.size() == 0) begin
          $error("result with nothing predicted: is_status %0b byte %0d status %0d len %0d",
                 out_is_status, out_payload_byte, out_frame_status, out_payload_len);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("is_status", want.is_status, out_is_status);
          check_field("payload_byte", want.payload_byte, out_payload_byte);
          check_field("frame_status", want.frame_status, out_frame_status);
          check_field("payload_len", want.payload_len, out_payload_len);
          if (want.is_status) begin
            status_seen[want.frame_status]++;
            // directed buffers also carry a hand-written status
            if (typed_status_q.size() != 0) begin
              want = typed_status_q.pop_front();
              check_field("frame_status (directed)", want.frame_status, out_frame_status);
              check_field("payload_len (directed)", want.payload_len, out_payload_len);
            end
          end
        end
      end
    end
  end

  // Receiver: random stalls at the phase's rate, plus a long hold-off on
  // request so the block backs up and stalls its input.
  always @(posedge clk) begin : receiver
    static int hold_served = 0;
    static int hold_left   = 0;
    if (hold_served != hold_req) begin
      hold_served = hold_req;
      hold_left   = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < rx_stall_pct);
    end
  end

  // Watchdog: no handshake of any kind for too long ends the run.
  always @(posedge clk) begin : watchdog
    static int quiet = 0;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG) begin
        $error("no handshake for %0d cycles, %0d items still due", WATCHDOG,
               pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  bench_row_t directed_rows [0:24] = '{
    // lone byte: too short, and with no header the length reads as zero
    '{8'hFF, 1'b1, 1'b1, ST_SHORT, 16'h0000},
    // reset registers, empty payload: CRC of nothing is zero, so all-zero is ok
    '{8'h00, 1'b0, 1'b0, ST_OK, 16'h0000},
    '{8'h00, 1'b0, 1'b0, ST_OK, 16'h0000},
    '{8'h00, 1'b0, 1'b0, ST_OK, 16'h0000},
    '{8'h00, 1'b0, 1'b0, ST_OK, 16'h0000},
    '{8'h00, 1'b0, 1'b0, ST_OK, 16'h0000},
    '{8'h00, 1'b0, 1'b0, ST_OK, 16'h0000},
    '{8'h00, 1'b0, 1'b0, ST_OK, 16'h0000},
    '{8'h00, 1'b1, 1'b1, ST_OK, 16'h0000},
    // first sync byte wrong, rest of the frame fine
    '{8'hFF, 1'b0, 1'b0, ST_OK, 16'h0000},
    '{8'h00, 1'b0, 1'b0, ST_OK, 16'h0000},
    '{8'h00, 1'b0, 1'b0, ST_OK, 16'h0000},
    '{8'h00, 1'b0, 1'b0, ST_OK, 16'h0000},
    '{8'h00, 1'b0, 1'b0, ST_OK, 16'h0000},
    '{8'h00, 1'b0, 1'b0, ST_OK, 16'h0000},
    '{8'h00, 1'b0, 1'b0, ST_OK, 16'h0000},
    '{8'h00, 1'b1, 1'b1, ST_SYNC, 16'h0000},
    // header claims the largest length; four payload bytes go out, the
    // last one together with the length error
    '{8'h00, 1'b0, 1'b0, ST_OK, 16'h0000},
    '{8'h00, 1'b0, 1'b0, ST_OK, 16'h0000},
    '{8'hFF, 1'b0, 1'b0, ST_OK, 16'h0000},
    '{8'hFF, 1'b0, 1'b0, ST_OK, 16'h0000},
    '{8'h11, 1'b0, 1'b0, ST_OK, 16'h0000},
    '{8'h22, 1'b0, 1'b0, ST_OK, 16'h0000},
    '{8'h33, 1'b0, 1'b0, ST_OK, 16'h0000},
    '{8'h44, 1'b1, 1'b1, ST_LEN, 16'hFFFF}
  };

  // Register plans and flow-control mixes, one per random phase. Both sync
  // extremes, a zero and a full-scale length limit and a limit of one appear.
  phase_plan_t plan [0:N_PHASES-1] = '{
    '{8'hA5, 8'h5A, 16'hFFFF, 7'd0,  7'd0,  1'b1},
    '{8'hFF, 8'hFF, 16'h0000, 7'd68, 7'd0,  1'b0},
    '{8'h00, 8'hFF, 16'h0010, 7'd0,  7'd68, 1'b0},
    '{8'h7E, 8'h81, 16'h00C8, 7'd6,  7'd6,  1'b1},
    '{8'hFF, 8'h00, 16'h0001, 7'd0,  7'd0,  1'b0},
    '{8'h12, 8'h34, 16'hFFFF, 7'd68, 7'd0,  1'b0},
    '{8'h00, 8'h00, 16'h0000, 7'd0,  7'd68, 1'b0},   // registers drawn at random
    '{8'h00, 8'h00, 16'hFFFF, 7'd6,  7'd6,  1'b0}
  };

  // Offer one byte and hold it until taken. Valid only drops in a sender gap.
  task automatic send_byte(input logic [7:0] b, input logic eob);
    while ($urandom_range(99, 0) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_data_byte     <= b;
    in_end_of_buffer <= eob;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic send_bytes(ref logic [7:0] fb[$]);
    foreach (fb[i]) send_byte(fb[i], i == fb.size() - 1);
  endtask

  // Drop valid, wait for every predicted item, then let the pipe empty.
  task automatic settle(input int extra);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  // All three registers, back to back; sync writes carry junk above bit 7.
  task automatic load_registers();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SYNC_FIRST;
    cfg_wdata <= {8'($urandom), gen_sa};
    @(posedge clk);
    cfg_index <= CFG_SYNC_SECOND;
    cfg_wdata <= {8'($urandom), gen_sb};
    @(posedge clk);
    cfg_index <= CFG_MAX_LEN;
    cfg_wdata <= gen_lim;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One random buffer. Mostly well-formed frames with random payload; the
  // rest short buffers, noise, oversize headers, bad sync, bad CRC and
  // frames cut off early (which can put a payload byte on the last byte).
  task automatic random_buffer(output int counted);
    logic [7:0]  fb[$];
    logic [7:0]  pb;
    logic [31:0] c;
    int          kind;
    int          len;
    int          n;
    int          headroom;
    logic        lenerr;
    kind   = $urandom_range(99, 0);
    lenerr = (kind >= 12 && kind < 20 && gen_lim != 16'hFFFF);
    if (kind < 12) begin
      n = (kind < 6) ? $urandom_range(7, 1) : $urandom_range(40, 8);
      if (kind < 6 && $urandom_range(1, 0) == 1) begin
        fb.push_back(gen_sa);
        fb.push_back(gen_sb);
      end
      while (fb.size() < n) fb.push_back(8'($urandom));
      while (fb.size() > n) void'(fb.pop_back());
    end else begin
      len = ($urandom_range(9, 0) != 0) ? $urandom_range(24, 0) : $urandom_range(300, 25);
      if (lenerr) begin
        headroom = 65534 - int'(gen_lim);
        if (headroom > 20) headroom = 20;
        len = int'(gen_lim) + 1 + $urandom_range(headroom, 0);
      end else if (len > int'(gen_lim))
        len = $urandom_range((gen_lim < 24) ? int'(gen_lim) : 24, 0);
      fb.push_back(gen_sa);
      fb.push_back(gen_sb);
      if (kind >= 20 && kind < 28) fb[$urandom_range(1, 0)] ^= 8'($urandom_range(255, 1));
      fb.push_back(len[7:0]);
      fb.push_back(len[15:8]);
      // oversize headers get at most a 30-byte slice of their payload
      n = len;
      if (lenerr && n > 30) n = $urandom_range(30, 0);
      c = 32'hFFFF_FFFF;
      repeat (n) begin
        pb = 8'($urandom);
        c  = crc32_update(c, pb);
        fb.push_back(pb);
      end
      c = ~c;
      if (kind >= 28 && kind < 38) c ^= ($urandom | 32'd1);
      for (int k = 0; k < 4; k++) fb.push_back(c[8*k +: 8]);
      if (kind >= 38 && kind < 46) repeat ($urandom_range(6, 1)) void'(fb.pop_back());
    end
    counted = fb.size();
    // bytes after a complete frame are ignored by the block
    if (kind >= 46 && $urandom_range(3, 0) == 0)
      repeat ($urandom_range(5, 1)) fb.push_back(8'($urandom));
    send_bytes(fb);
  endtask

  initial begin : stimulus
    int          counted;
    int          n;
    int          statuses;
    phase_plan_t pp;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed buffers run under the reset register values
    foreach (directed_rows[i]) begin
      if (directed_rows[i].typed)
        typed_status_q.push_back('{1'b1, 8'd0, directed_rows[i].status, directed_rows[i].len});
      send_byte(directed_rows[i].data, directed_rows[i].eob);
    end
    settle(4);

    for (int p = 0; p < N_PHASES; p++) begin
      pp      = plan[p];
      gen_sa  = pp.sync_a;
      gen_sb  = pp.sync_b;
      gen_lim = pp.lim;
      if (p == 6) begin
        gen_sa  = 8'($urandom);
        gen_sb  = 8'($urandom);
        gen_lim = 16'($urandom_range(40, 0));
      end
      tx_gap_pct   = pp.tx_pct;
      rx_stall_pct = pp.rx_pct;
      load_registers();
      if (pp.hold) hold_req++;
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        random_buffer(n);
        counted += n;
      end
      settle(4);
    end

    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d predicted items never arrived", pending_results.size());
      mismatches++;
    end
    statuses = status_seen[0] + status_seen[1] + status_seen[2] + status_seen[3]
             + status_seen[4];
    $display("Run covered %0d buffers and %0d result items over nine register plans,",
             statuses, results_checked);
    $display("with statuses ok %0d, short %0d, sync %0d, length %0d, crc %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
